// ===== rtl/vbpd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, mode codes and constants for the byte-pair pixel decoder.
package vbpd_pkg;

	localparam int ADDR_W  = 13;
	localparam int BYTE_W  = 8;
	localparam int SLOT_W  = 4;
	localparam int NPIX    = 16;
	localparam int ROW_W   = SLOT_W * NPIX;

	// Incoming mode codes
	localparam logic [3:0] FUNC_COL40    = 4'd0;
	localparam logic [3:0] FUNC_BITMAP4  = 4'd1;
	localparam logic [3:0] FUNC_PAGE1    = 4'd2;
	localparam logic [3:0] FUNC_PAGE2    = 4'd3;
	localparam logic [3:0] FUNC_STACK2   = 4'd4;
	localparam logic [3:0] FUNC_COL80    = 4'd5;
	localparam logic [3:0] FUNC_STACK4   = 4'd6;
	localparam logic [3:0] FUNC_BITMAP4B = 4'd7;
	localparam logic [3:0] FUNC_BITMAP16 = 4'd8;
	localparam logic [3:0] FUNC_PALETTE  = 4'd9;

	// Resolved decode kind, after folding unknown codes and the palette area
	typedef enum logic [3:0] {
		K_COL40,
		K_BITMAP4,
		K_PAGE1,
		K_PAGE2,
		K_STACK2,
		K_COL80,
		K_STACK4,
		K_BITMAP4B,
		K_BITMAP16,
		K_SWATCH
	} kind_t;

	localparam logic [BYTE_W-1:0] SWATCH_MASK  = 8'h78;
	localparam logic [BYTE_W-1:0] SWATCH_MATCH = 8'h30;
	localparam logic [SLOT_W-1:0] SLOT_SW_LO   = 4'd7;
	localparam logic [SLOT_W-1:0] SLOT_SW_HI   = 4'd8;

	// Stage 1 bundle
	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [BYTE_W-1:0] form;
		logic [BYTE_W-1:0] color;
	} s1_t;

endpackage

// ===== rtl/vbpd_decode.sv =====
`timescale 1ns / 1ps
// Stage 1: mode classification and palette area compare.
module vbpd_decode import vbpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  logic [3:0]        func,
	input  logic [ADDR_W-1:0] vram_address,
	input  logic [BYTE_W-1:0] form_byte,
	input  logic [BYTE_W-1:0] color_byte,
	input  logic [ADDR_W-1:0] palette_area_end,
	output s1_t               st_s1
);

	kind_t             kind;
	logic              valid_s1;
	kind_t             kind_s1;
	logic [BYTE_W-1:0] form_s1;
	logic [BYTE_W-1:0] color_s1;

	always_comb begin
		unique case (func)
			FUNC_BITMAP4:  kind = K_BITMAP4;
			FUNC_PAGE1:    kind = K_PAGE1;
			FUNC_PAGE2:    kind = K_PAGE2;
			FUNC_STACK2:   kind = K_STACK2;
			FUNC_COL80:    kind = K_COL80;
			FUNC_STACK4:   kind = K_STACK4;
			FUNC_BITMAP4B: kind = K_BITMAP4B;
			FUNC_BITMAP16: kind = K_BITMAP16;
			FUNC_PALETTE:  kind = (vram_address < palette_area_end) ? K_SWATCH : K_COL40;
			default:       kind = K_COL40;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			kind_s1  <= kind;
			form_s1  <= form_byte;
			color_s1 <= color_byte;
		end
	end

	assign st_s1 = '{valid: valid_s1, kind: kind_s1, form: form_s1, color: color_s1};

endmodule

// ===== rtl/vbpd_expand.sv =====
`timescale 1ns / 1ps
// Stage 2: expand the byte pair into sixteen palette slots.
module vbpd_expand import vbpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  s1_t              st_s1,
	output logic             valid_s2,
	output logic [ROW_W-1:0] row_s2,
	output logic             direct_s2
);

	logic [ROW_W-1:0]  row;
	logic [SLOT_W-1:0] slot;
	logic [SLOT_W-1:0] fg, bg, sw_a, sw_b;
	logic [15:0]       fc;

	assign fc   = {st_s1.form, st_s1.color};
	assign fg   = {~st_s1.color[6], st_s1.color[5:3]};
	assign bg   = {~st_s1.color[7], st_s1.color[2:0]};
	assign sw_a = ((st_s1.color & SWATCH_MASK) == SWATCH_MATCH) ? SLOT_SW_LO : SLOT_SW_HI;
	assign sw_b = ((st_s1.color & SWATCH_MASK) == SWATCH_MATCH) ? SLOT_SW_HI : SLOT_SW_LO;

	// Each pixel is independent; pixel i lands in bits 63-4i down.
	always_comb begin
		row = '0;
		for (int i = 0; i < NPIX; i++) begin
			slot = '0;
			unique case (st_s1.kind)
				K_BITMAP4:
					slot = {2'b00, st_s1.form[7 - i/2], st_s1.color[7 - i/2]};
				K_PAGE1:
					slot = {3'b000, st_s1.form[7 - i/2]};
				K_PAGE2:
					slot = {2'b00, st_s1.form[7 - i/2], 1'b0};
				K_STACK2:
					slot = st_s1.form[7 - i/2] ? 4'd1 :
					       (st_s1.color[7 - i/2] ? 4'd2 : 4'd0);
				K_COL80:
					slot = {3'b000, fc[15 - i]};
				K_STACK4:
					slot = st_s1.form[7 - i/4]  ? 4'd1 :
					       st_s1.form[3 - i/4]  ? 4'd2 :
					       st_s1.color[7 - i/4] ? 4'd3 :
					       st_s1.color[3 - i/4] ? 4'd4 : 4'd0;
				K_BITMAP4B:
					slot = {2'b00, fc[15 - 2*(i/2) -: 2]};
				K_BITMAP16:
					slot = fc[15 - 4*(i/4) -: 4];
				K_SWATCH:
					slot = st_s1.form[7 - i/2] ? sw_a : sw_b;
				default:
					slot = st_s1.form[7 - i/2] ? fg : bg;
			endcase
			row[ROW_W-1 - SLOT_W*i -: SLOT_W] = slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= st_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && st_s1.valid) begin
			row_s2    <= row;
			direct_s2 <= (st_s1.kind == K_SWATCH);
		end
	end

endmodule

// ===== rtl/video_byte_pair_pixel_decoder_top.sv =====
`timescale 1ns / 1ps
// Top level of the byte-pair pixel decoder: handshake, config register, output stage.
// An accepted input beat reaches the output through the decode, expand and output registers.
// Throughput: one beat per cycle while out_stall is low; three register stages (decode, expand, output).
// Each stage advances when it is empty or the stage after it advances, so bubbles collapse.
// Reset: arst_n clears all stage valid bits and sets palette_area_end to 0.
// cfg_ready is always high; a config beat is taken in the cycle it is offered.
module video_byte_pair_pixel_decoder_top import vbpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [3:0]        func,
	input  logic [ADDR_W-1:0] vram_address,
	input  logic [BYTE_W-1:0] form_byte,
	input  logic [BYTE_W-1:0] color_byte,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ROW_W-1:0]  pixel_row,
	output logic              direct_index,
	// config write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ADDR_W-1:0] cfg_data
);

	logic [ADDR_W-1:0] palette_area_end_q;
	s1_t               st_s1;
	logic              valid_s2, direct_s2;
	logic [ROW_W-1:0]  row_s2;
	logic              adv1, adv2, adv3;

	// Stage enables: a stage moves when its slot is empty or downstream moves.
	assign adv3     = !out_valid || !out_stall;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !st_s1.valid || adv2;
	assign in_stall = !adv1;

	// Config register: always ready, written only while idle by contract.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_area_end_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			palette_area_end_q <= cfg_data;
		end
	end

	// Stage 1: classify the mode, compare the address against the palette area.
	vbpd_decode u_decode (
		.clk              (clk),
		.arst_n           (arst_n),
		.adv              (adv1),
		.in_valid         (in_valid),
		.func             (func),
		.vram_address     (vram_address),
		.form_byte        (form_byte),
		.color_byte       (color_byte),
		.palette_area_end (palette_area_end_q),
		.st_s1            (st_s1)
	);

	// Stage 2: expand to sixteen slots.
	vbpd_expand u_expand (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv2),
		.st_s1     (st_s1),
		.valid_s2  (valid_s2),
		.row_s2    (row_s2),
		.direct_s2 (direct_s2)
	);

	// Stage 3: output register; hold the beat while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv3) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			pixel_row    <= row_s2;
			direct_index <= direct_s2;
		end
	end

	// An accepted input beat always occupies stage 1 next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> st_s1.valid)
		else $error("accepted beat did not reach stage 1");

	// A stalled stage 2 beat must not be dropped.
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !adv3 |=> valid_s2 && $stable(row_s2))
		else $error("stage 2 beat lost under stall");

	// Backpressure reaches the input only when every stage is full.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall && valid_s2 && st_s1.valid)
		else $error("input stalled with a free stage");

	// Swatch rows contain only the two raw indices; the check looks at the first pixel slot.
	a_direct_values: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && direct_index |->
			(pixel_row[63:60] == SLOT_SW_LO || pixel_row[63:60] == SLOT_SW_HI))
		else $error("direct row carries a non-swatch index");

endmodule
